### src/assert_macros.svh
// Assertion macros shared by the region-mean RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/gbrm_pkg.sv
// Types and constants of the region-mean block.
package gbrm_pkg;

  localparam int REQ_W       = 2;
  localparam int REGION_W    = 10;
  localparam int VALUE_W     = 32;
  localparam int CFG_W       = 11;
  localparam int COUNT_OUT_W = 16;
  localparam int CNT_EXT_W   = 32;
  localparam int EXT_W       = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACCUM = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CFG_W-1:0]   CFG_RESET = 11'd1024;
  localparam logic [VALUE_W-1:0] MEAN_MAX  = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] MEAN_MIN  = 32'h8000_0000;

  // Work kinds handed from the front to the back.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2,
    OP_MISS  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t                    kind;
    logic [REGION_W-1:0]         region;
    logic signed [VALUE_W-1:0]   value;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

### src/gbrm_channels.sv
// Valid/ready channel interfaces for request and result transactions.
interface gbrm_in_if;
  import gbrm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [REGION_W-1:0]       region_index;
  logic signed [VALUE_W-1:0] cell_value;
  modport source(output valid, req_type, region_index, cell_value, input ready);
  modport sink(input valid, req_type, region_index, cell_value, output ready);
endinterface

interface gbrm_out_if;
  import gbrm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] mean_value;
  logic [COUNT_OUT_W-1:0]    region_count;
  logic                      region_empty;
  logic                      sum_saturated;
  modport source(output valid, mean_value, region_count, region_empty, sum_saturated,
                 input ready);
  modport sink(input valid, mean_value, region_count, region_empty, sum_saturated,
               output ready);
endinterface

### src/group_by_region_mean.sv
// Per-region sum/count table with mean readout. Requests (clear, accumulate, read) enter
// through in_ch and are classified into a two-entry queue; a table engine behind it works one
// request at a time out of a region memory with one read and one write port. Accumulate is a
// memory read, then a saturating add and write back. Read runs the one-bit-per-cycle restoring
// divider and delivers one result on out_ch; a read of an unused region skips the divider.
// Clear writes one region per cycle over every region in use. After reset the engine zeroes all
// NUM_REGIONS entries, one per cycle, and in_ch.ready stays low during that sweep; cfg writes
// are taken throughout. Write cfg only while the block is idle.
module group_by_region_mean #(
  parameter int NUM_REGIONS = 1024,
  parameter int SUM_WIDTH   = 48,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  gbrm_in_if.sink                      in_ch,
  gbrm_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [gbrm_pkg::CFG_W-1:0]   cfg_wdata
);
  import gbrm_pkg::*;

  localparam int AW = $clog2(NUM_REGIONS);

  logic [CFG_W-1:0] regions_in_use_r, regions_in_use_nxt;
  logic [EXT_W-1:0] cfg_ext;
  logic [EXT_W-1:0] clamp_ext;
  logic [AW:0]      active_n;

  logic        q_full;
  logic        push;
  op_t         push_op;
  logic        pop;
  queue_head_t head;
  logic        init_busy;

  assign regions_in_use_nxt = cfg_we ? cfg_wdata : regions_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regions_in_use_r <= CFG_RESET;
    end else begin
      regions_in_use_r <= regions_in_use_nxt;
    end
  end

  // zero acts as one, anything above the table size as the table size
  assign cfg_ext = EXT_W'(regions_in_use_r);
  always_comb begin
    if (cfg_ext == '0) begin
      clamp_ext = EXT_W'(1);
    end else if (cfg_ext > EXT_W'(NUM_REGIONS)) begin
      clamp_ext = EXT_W'(NUM_REGIONS);
    end else begin
      clamp_ext = cfg_ext;
    end
  end
  assign active_n = clamp_ext[AW:0];

  gbrm_front #(
    .AW(AW)
  ) u_front (
    .in_ch     (in_ch),
    .active_n  (active_n),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  gbrm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .head    (head)
  );

  gbrm_back #(
    .NUM_REGIONS (NUM_REGIONS),
    .SUM_WIDTH   (SUM_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .active_n  (active_n),
    .head      (head),
    .pop       (pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

### src/gbrm_front.sv
// Request front end: accept, range-check and classify request transactions.
module gbrm_front #(
  parameter int AW = 10
) (
  gbrm_in_if.sink            in_ch,
  input  logic [AW:0]        active_n,
  input  logic               init_busy,
  input  logic               q_full,
  output logic               push,
  output gbrm_pkg::op_t      push_op
);
  import gbrm_pkg::*;

  logic [EXT_W-1:0] region_ext;
  logic [EXT_W-1:0] limit_ext;
  logic             in_range;
  logic             take;

  assign region_ext  = EXT_W'(in_ch.region_index);
  assign limit_ext   = EXT_W'(active_n);
  assign in_range    = region_ext < limit_ext;
  assign in_ch.ready = !q_full && !init_busy;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_op.region = in_ch.region_index;
    push_op.value  = in_ch.cell_value;
    push_op.kind   = OP_CLEAR;
    push           = 1'b0;
    case (in_ch.req_type)
      REQ_CLEAR: begin
        push_op.kind = OP_CLEAR;
        push         = take;
      end
      REQ_ACCUM: begin
        // drop accumulates to regions outside the table in use
        push_op.kind = OP_ACCUM;
        push         = take && in_range;
      end
      REQ_READ: begin
        push_op.kind = in_range ? OP_READ : OP_MISS;
        push         = take;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

### src/gbrm_queue.sv
// Short FIFO of classified work between the front end and the table engine.
`include "assert_macros.svh"

module gbrm_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  gbrm_pkg::op_t          push_op,
  input  logic                   pop,
  output logic                   full,
  output gbrm_pkg::queue_head_t  head
);
  import gbrm_pkg::*;

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign head.valid = cnt_r != '0;
  assign head.op    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && full, "push into full queue")
  `ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && !head.valid, "pop from empty queue")

endmodule

### src/gbrm_back.sv
// Table engine: region memory, clear sweep, accumulate RMW, mean divider, result register.
`include "assert_macros.svh"

module gbrm_back #(
  parameter int NUM_REGIONS = 1024,
  parameter int SUM_WIDTH   = 48,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(NUM_REGIONS):0]    active_n,
  input  gbrm_pkg::queue_head_t           head,
  output logic                            pop,
  output logic                            init_busy,
  gbrm_out_if.source                      out_ch
);
  import gbrm_pkg::*;

  localparam int AW     = $clog2(NUM_REGIONS);
  localparam int WORD_W = SUM_WIDTH + COUNT_WIDTH + 1;
  localparam int STEP_W = $clog2(SUM_WIDTH);
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CLEAR = 7'b0000100,
    S_ACCUM = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // region table: {sat flag, count, sum}
  logic [WORD_W-1:0] mem [NUM_REGIONS];
  logic [WORD_W-1:0] rd_word_r;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_word;

  logic [EXT_W-1:0] region_ext;
  logic [AW-1:0]    head_addr;

  logic [AW-1:0]             sweep_r, sweep_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;

  logic [SUM_WIDTH-1:0]   dvd_r, dvd_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] div_r, div_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   neg_r, neg_nxt;
  logic                   empty_r, empty_nxt;
  logic [COUNT_WIDTH-1:0] cnt_hold_r, cnt_hold_nxt;
  logic                   sat_hold_r, sat_hold_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]        mean_r, mean_nxt;
  logic [COUNT_OUT_W-1:0]    count_r, count_nxt;
  logic                      empty_out_r, empty_out_nxt;
  logic                      sat_out_r, sat_out_nxt;

  logic [SUM_WIDTH-1:0]   rd_sum;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic                   rd_sat;
  logic [SUM_WIDTH:0]     acc_wide;
  logic                   acc_ovf;
  logic [SUM_WIDTH-1:0]   acc_sum;
  logic [COUNT_WIDTH-1:0] acc_cnt;
  logic [SUM_WIDTH-1:0]   rd_mag;
  logic [COUNT_WIDTH:0]   rem_shift;
  logic [COUNT_WIDTH:0]   rem_sub;
  logic                   rem_ge;
  logic                   pos_big;
  logic                   neg_big;
  logic [VALUE_W-1:0]     mean_res;
  logic [CNT_EXT_W-1:0]   cnt_ext;
  logic                   out_free;

  assign region_ext = EXT_W'(head.op.region);
  assign head_addr  = region_ext[AW-1:0];
  assign pop        = (state_r == S_IDLE) && head.valid;
  assign init_busy  = state_r == S_INIT;

  assign rd_sum = rd_word_r[SUM_WIDTH-1:0];
  assign rd_cnt = rd_word_r[SUM_WIDTH +: COUNT_WIDTH];
  assign rd_sat = rd_word_r[WORD_W-1];

  // saturating accumulate
  assign acc_wide = {rd_sum[SUM_WIDTH-1], rd_sum}
                  + {{(SUM_WIDTH + 1 - VALUE_W){value_r[VALUE_W-1]}}, value_r};
  assign acc_ovf  = acc_wide[SUM_WIDTH] != acc_wide[SUM_WIDTH-1];
  assign acc_sum  = acc_ovf ? (acc_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX)
                            : acc_wide[SUM_WIDTH-1:0];
  assign acc_cnt  = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
  assign rd_mag   = rd_sum[SUM_WIDTH-1] ? (~rd_sum + 1'b1) : rd_sum;

  // one restoring division step per cycle on magnitudes
  assign rem_shift = {rem_r, dvd_r[SUM_WIDTH-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_r};
  assign rem_sub   = rem_shift - {1'b0, div_r};

  // clamp the quotient to the 32-bit signed range and restore the sign
  assign pos_big = |dvd_r[SUM_WIDTH-1:VALUE_W-1];
  assign neg_big = (|dvd_r[SUM_WIDTH-1:VALUE_W]) ||
                   (dvd_r[VALUE_W-1] && |dvd_r[VALUE_W-2:0]);
  always_comb begin
    if (empty_r) begin
      mean_res = '0;
    end else if (!neg_r) begin
      mean_res = pos_big ? MEAN_MAX : dvd_r[VALUE_W-1:0];
    end else begin
      mean_res = neg_big ? MEAN_MIN : (~dvd_r[VALUE_W-1:0] + 1'b1);
    end
  end

  assign cnt_ext  = CNT_EXT_W'(cnt_hold_r);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    addr_nxt      = addr_r;
    value_nxt     = value_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    step_nxt      = step_r;
    neg_nxt       = neg_r;
    empty_nxt     = empty_r;
    cnt_hold_nxt  = cnt_hold_r;
    sat_hold_nxt  = sat_hold_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    mean_nxt      = mean_r;
    count_nxt     = count_r;
    empty_out_nxt = empty_out_r;
    sat_out_nxt   = sat_out_r;
    wr_en         = 1'b0;
    wr_addr       = sweep_r;
    wr_word       = '0;
    case (state_r)
      S_INIT: begin
        wr_en     = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(NUM_REGIONS - 1)) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          addr_nxt  = head_addr;
          value_nxt = head.op.value;
          case (head.op.kind)
            OP_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = S_CLEAR;
            end
            OP_ACCUM: state_nxt = S_ACCUM;
            OP_READ:  state_nxt = S_LOAD;
            OP_MISS: begin
              cnt_hold_nxt = '0;
              sat_hold_nxt = 1'b0;
              empty_nxt    = 1'b1;
              state_nxt    = S_DONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        wr_en     = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if ({1'b0, sweep_r} == active_n - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      S_ACCUM: begin
        wr_en     = 1'b1;
        wr_addr   = addr_r;
        wr_word   = {rd_sat | acc_ovf, acc_cnt, acc_sum};
        state_nxt = S_IDLE;
      end
      S_LOAD: begin
        cnt_hold_nxt = rd_cnt;
        sat_hold_nxt = rd_sat;
        neg_nxt      = rd_sum[SUM_WIDTH-1];
        dvd_nxt      = rd_mag;
        rem_nxt      = '0;
        div_nxt      = rd_cnt;
        step_nxt     = STEP_W'(SUM_WIDTH - 1);
        if (rd_cnt == '0) begin
          empty_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          empty_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_ge ? rem_sub[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
        dvd_nxt  = {dvd_r[SUM_WIDTH-2:0], rem_ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold the finished result until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          mean_nxt      = mean_res;
          count_nxt     = (|cnt_ext[CNT_EXT_W-1:COUNT_OUT_W]) ? '1
                                                              : cnt_ext[COUNT_OUT_W-1:0];
          empty_out_nxt = empty_r;
          sat_out_nxt   = sat_hold_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    value_r     <= value_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    step_r      <= step_nxt;
    neg_r       <= neg_nxt;
    empty_r     <= empty_nxt;
    cnt_hold_r  <= cnt_hold_nxt;
    sat_hold_r  <= sat_hold_nxt;
    mean_r      <= mean_nxt;
    count_r     <= count_nxt;
    empty_out_r <= empty_out_nxt;
    sat_out_r   <= sat_out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word_r <= mem[head_addr];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mean_value    = mean_r;
  assign out_ch.region_count  = count_r;
  assign out_ch.region_empty  = empty_out_r;
  assign out_ch.sum_saturated = sat_out_r;

  `ASSERT_IMPLIES(a_no_pop_in_init, clk, rst_n, state_r == S_INIT, !pop, "pop during init sweep")
  `ASSERT_NEXT(a_accum_one_write, clk, rst_n, state_r == S_ACCUM, state_r == S_IDLE, "accumulate overran")
  `ASSERT_NEXT(a_div_ends, clk, rst_n, (state_r == S_DIV) && (step_r == '0), state_r == S_DONE, "divider did not finish")

endmodule
